FILE: rtl/assert_macros.svh
// Assertion macros shared by the PS/2 scan code translator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/ps2sc_pkg.sv
// Package for the PS/2 scan code set 2 to ASCII translator.
// Holds scan code constants, the key state flag type and the character tables.
package ps2sc_pkg;

   localparam logic [7:0] CODE_EXT    = 8'hE0;
   localparam logic [7:0] CODE_REL    = 8'hF0;
   localparam logic [7:0] CODE_CAPS   = 8'h58;
   localparam logic [7:0] CODE_LSHIFT = 8'h12;
   localparam logic [7:0] CODE_RSHIFT = 8'h59;
   localparam logic [7:0] CODE_MOD11  = 8'h11;

   typedef struct packed {
      logic release_pending;
      logic extended_pending;
      logic caps_lock;
      logic shift_down;
      logic mod11_down;
   } flags_type;

   function automatic logic [6:0] base_char(input logic [7:0] code);
      logic [6:0] ch;
      unique case (code)
         8'h76: ch = 7'h1B;
         8'h0E: ch = 7'h60;
         8'h16: ch = 7'h31;
         8'h1E: ch = 7'h32;
         8'h26: ch = 7'h33;
         8'h25: ch = 7'h34;
         8'h2E: ch = 7'h35;
         8'h36: ch = 7'h36;
         8'h3D: ch = 7'h37;
         8'h3E: ch = 7'h38;
         8'h46: ch = 7'h39;
         8'h45: ch = 7'h30;
         8'h4E: ch = 7'h2D;
         8'h55: ch = 7'h3D;
         8'h66: ch = 7'h08;
         8'h0D: ch = 7'h09;
         8'h15: ch = 7'h71;
         8'h1D: ch = 7'h77;
         8'h24: ch = 7'h65;
         8'h2D: ch = 7'h72;
         8'h2C: ch = 7'h74;
         8'h35: ch = 7'h79;
         8'h3C: ch = 7'h75;
         8'h43: ch = 7'h69;
         8'h44: ch = 7'h6F;
         8'h4D: ch = 7'h70;
         8'h54: ch = 7'h5B;
         8'h5B: ch = 7'h5D;
         8'h5D: ch = 7'h5C;
         8'h1C: ch = 7'h61;
         8'h1B: ch = 7'h73;
         8'h23: ch = 7'h64;
         8'h2B: ch = 7'h66;
         8'h34: ch = 7'h67;
         8'h33: ch = 7'h68;
         8'h3B: ch = 7'h6A;
         8'h42: ch = 7'h6B;
         8'h4B: ch = 7'h6C;
         8'h4C: ch = 7'h3B;
         8'h52: ch = 7'h27;
         8'h5A: ch = 7'h0A;
         8'h1A: ch = 7'h7A;
         8'h22: ch = 7'h78;
         8'h21: ch = 7'h63;
         8'h2A: ch = 7'h76;
         8'h32: ch = 7'h62;
         8'h31: ch = 7'h6E;
         8'h3A: ch = 7'h6D;
         8'h41: ch = 7'h2C;
         8'h49: ch = 7'h2E;
         8'h4A: ch = 7'h2F;
         8'h29: ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [6:0] alt_char(input logic [7:0] code);
      logic [6:0] ch;
      unique case (code)
         8'h0E: ch = 7'h7E;
         8'h16: ch = 7'h21;
         8'h1E: ch = 7'h40;
         8'h26: ch = 7'h23;
         8'h25: ch = 7'h24;
         8'h2E: ch = 7'h25;
         8'h36: ch = 7'h5E;
         8'h3D: ch = 7'h26;
         8'h3E: ch = 7'h2A;
         8'h46: ch = 7'h28;
         8'h45: ch = 7'h29;
         8'h4E: ch = 7'h5F;
         8'h55: ch = 7'h2B;
         8'h15: ch = 7'h51;
         8'h1D: ch = 7'h57;
         8'h24: ch = 7'h45;
         8'h2D: ch = 7'h52;
         8'h2C: ch = 7'h54;
         8'h35: ch = 7'h59;
         8'h3C: ch = 7'h55;
         8'h43: ch = 7'h49;
         8'h44: ch = 7'h4F;
         8'h4D: ch = 7'h50;
         8'h54: ch = 7'h7B;
         8'h5B: ch = 7'h7D;
         8'h5D: ch = 7'h7C;
         8'h1C: ch = 7'h41;
         8'h1B: ch = 7'h53;
         8'h23: ch = 7'h44;
         8'h2B: ch = 7'h46;
         8'h34: ch = 7'h47;
         8'h33: ch = 7'h48;
         8'h3B: ch = 7'h4A;
         8'h42: ch = 7'h4B;
         8'h4B: ch = 7'h4C;
         8'h4C: ch = 7'h3A;
         8'h52: ch = 7'h22;
         8'h1A: ch = 7'h5A;
         8'h22: ch = 7'h58;
         8'h21: ch = 7'h43;
         8'h2A: ch = 7'h56;
         8'h32: ch = 7'h42;
         8'h31: ch = 7'h4E;
         8'h3A: ch = 7'h4D;
         8'h41: ch = 7'h3C;
         8'h49: ch = 7'h3E;
         8'h4A: ch = 7'h3F;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: rtl/ps2_scancode_to_ascii.sv
// Top level of the PS/2 scan code set 2 to ASCII translator.
// Depends on ps2sc_pkg, ps2sc_key_state, ps2sc_xlate and assert_macros.svh.
// An accepted request waits in the input register until the response register is free.
// One transaction per cycle while rsp_ready is high; the two registers decouple the sides.
// A synchronous reset clears all key flags and both valid registers.
`include "assert_macros.svh"
module ps2_scancode_to_ascii (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_ascii_char,
   output logic       rsp_shift_held,
   output logic       rsp_caps_active,
   output logic       rsp_mod11_held
);
   import ps2sc_pkg::*;

   logic       in_valid_ff;
   logic [7:0] scan_ff;
   logic       rsp_valid_ff;
   logic [6:0] ascii_ff;
   logic       shift_ff;
   logic       caps_ff;
   logic       mod11_ff;
   logic       advance;
   logic [6:0] ascii_in;
   flags_type  flags_ff;
   flags_type  flags_in;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   ps2sc_key_state u_key_state (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .code     (scan_ff),
      .flags_ff (flags_ff),
      .flags_in (flags_in)
   );

   ps2sc_xlate u_xlate (
      .code  (scan_ff),
      .flags (flags_ff),
      .ascii (ascii_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         scan_ff <= req_scan_byte;
      end
      if (advance) begin
         ascii_ff <= ascii_in;
         shift_ff <= flags_in.shift_down;
         caps_ff  <= flags_in.caps_lock;
         mod11_ff <= flags_in.mod11_down;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ascii_char  = ascii_ff;
   assign rsp_shift_held  = shift_ff;
   assign rsp_caps_active = caps_ff;
   assign rsp_mod11_held  = mod11_ff;

   `ASSERT_NEXT(a_release_no_char, clock, reset, advance && flags_ff.release_pending,
                rsp_valid_ff && ascii_ff == 7'h00)
   `ASSERT_SAME(a_flags_match, clock, reset, rsp_valid_ff,
                shift_ff == flags_ff.shift_down && caps_ff == flags_ff.caps_lock)
   `ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid_ff && !rsp_ready,
                rsp_valid_ff && $stable(ascii_ff))

endmodule

FILE: rtl/ps2sc_key_state.sv
// Key state flags of the translator: prefixes, caps lock, shift and key 0x11.
// Depends on ps2sc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ps2sc_key_state (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           code,
   output ps2sc_pkg::flags_type flags_ff,
   output ps2sc_pkg::flags_type flags_in
);
   import ps2sc_pkg::*;

   always_comb begin
      flags_in = flags_ff;
      if (code == CODE_REL) begin
         flags_in.release_pending = 1'b1;
      end else begin
         priority if (code == CODE_EXT) begin
            flags_in.extended_pending = 1'b1;
         end else if (code == CODE_CAPS) begin
            if (!flags_ff.release_pending) begin
               flags_in.caps_lock = !flags_ff.caps_lock;
            end
         end else if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
            flags_in.shift_down = !flags_ff.release_pending;
         end else if (code == CODE_MOD11) begin
            flags_in.mod11_down = !flags_ff.release_pending;
         end else begin
            flags_in.extended_pending = 1'b0;
         end
         flags_in.release_pending = 1'b0;
         if (code != CODE_EXT) begin
            flags_in.extended_pending = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (step) begin
         flags_ff <= flags_in;
      end
   end

   `ASSERT_NEXT(a_rel_sets, clock, reset, step && code == CODE_REL,
                flags_ff.release_pending)
   `ASSERT_NEXT(a_ext_sets, clock, reset, step && code == CODE_EXT,
                flags_ff.extended_pending && !flags_ff.release_pending)
   `ASSERT_NEXT(a_idle_holds, clock, reset, !step, $stable(flags_ff))
   `ASSERT_NEXT(a_caps_toggle, clock, reset,
                step && code == CODE_CAPS && !flags_ff.release_pending,
                flags_ff.caps_lock != $past(flags_ff.caps_lock))

endmodule

FILE: rtl/ps2sc_xlate.sv
// Character lookup: maps a scan code and the current flags to an ASCII code.
// Depends on ps2sc_pkg.
module ps2sc_xlate (
   input  logic [7:0]           code,
   input  ps2sc_pkg::flags_type flags,
   output logic [6:0]           ascii
);
   import ps2sc_pkg::*;

   logic [6:0] base_ch;
   logic [6:0] alt_ch;

   always_comb begin
      base_ch = base_char(code);
      alt_ch  = alt_char(code);
      ascii   = 7'h00;
      if (!flags.release_pending) begin
         if ((flags.caps_lock != flags.shift_down) && alt_ch != 7'h00) begin
            ascii = alt_ch;
         end else begin
            ascii = base_ch;
         end
      end
   end

endmodule

FILE: tb/ps2_scancode_checker.sv
// Response checker for the PS/2 scan code to ASCII translator testbench.
// Keeps its own key flags, predicts each response and compares it field by field.
// Depends on ps2sc_pkg for the scan code constants.
module ps2_scancode_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_scan_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [6:0] rsp_ascii_char,
   input  logic       rsp_shift_held,
   input  logic       rsp_caps_active,
   input  logic       rsp_mod11_held,
   output int         fail_count,
   output int         pending,
   output int         checked,
   output int         char_count
);
   import ps2sc_pkg::*;

   typedef struct packed {
      logic [6:0] ascii_char;
      logic       shift_held;
      logic       caps_active;
      logic       mod11_held;
   } key_result_type;

   key_result_type expected_q[$];
   int mismatches = 0;

   logic release_seen = 1'b0;
   logic extended_seen = 1'b0;
   logic caps_on = 1'b0;
   logic shift_on = 1'b0;
   logic mod11_on = 1'b0;

   assign fail_count = mismatches;

   initial begin
      pending = 0;
      checked = 0;
      char_count = 0;
   end

   // Returns {shifted character, plain character}; zero where a key has none.
   function automatic logic [15:0] key_glyphs(input logic [7:0] code);
      logic [15:0] g;
      case (code)
         8'h76: g = {8'h00, 8'h1B};
         8'h0E: g = {"~", 8'h60};
         8'h16: g = {"!", "1"};
         8'h1E: g = {"@", "2"};
         8'h26: g = {"#", "3"};
         8'h25: g = {"$", "4"};
         8'h2E: g = {"%", "5"};
         8'h36: g = {"^", "6"};
         8'h3D: g = {"&", "7"};
         8'h3E: g = {"*", "8"};
         8'h46: g = {"(", "9"};
         8'h45: g = {")", "0"};
         8'h4E: g = {"_", "-"};
         8'h55: g = {"+", "="};
         8'h66: g = {8'h00, 8'h08};
         8'h0D: g = {8'h00, 8'h09};
         8'h15: g = {"Q", "q"};
         8'h1D: g = {"W", "w"};
         8'h24: g = {"E", "e"};
         8'h2D: g = {"R", "r"};
         8'h2C: g = {"T", "t"};
         8'h35: g = {"Y", "y"};
         8'h3C: g = {"U", "u"};
         8'h43: g = {"I", "i"};
         8'h44: g = {"O", "o"};
         8'h4D: g = {"P", "p"};
         8'h54: g = {"{", "["};
         8'h5B: g = {"}", "]"};
         8'h5D: g = {"|", 8'h5C};
         8'h1C: g = {"A", "a"};
         8'h1B: g = {"S", "s"};
         8'h23: g = {"D", "d"};
         8'h2B: g = {"F", "f"};
         8'h34: g = {"G", "g"};
         8'h33: g = {"H", "h"};
         8'h3B: g = {"J", "j"};
         8'h42: g = {"K", "k"};
         8'h4B: g = {"L", "l"};
         8'h4C: g = {":", ";"};
         8'h52: g = {8'h22, "'"};
         8'h5A: g = {8'h00, 8'h0A};
         8'h1A: g = {"Z", "z"};
         8'h22: g = {"X", "x"};
         8'h21: g = {"C", "c"};
         8'h2A: g = {"V", "v"};
         8'h32: g = {"B", "b"};
         8'h31: g = {"N", "n"};
         8'h3A: g = {"M", "m"};
         8'h41: g = {"<", ","};
         8'h49: g = {">", "."};
         8'h4A: g = {"?", "/"};
         8'h29: g = {8'h00, " "};
         default: g = 16'h0000;
      endcase
      return g;
   endfunction

   function automatic key_result_type translate_byte(input logic [7:0] code);
      key_result_type r;
      logic [15:0] glyphs;
      glyphs = key_glyphs(code);
      r = '0;
      if (code == CODE_REL) begin
         release_seen = 1'b1;
      end else begin
         if (code == CODE_EXT) begin
            extended_seen = 1'b1;
         end else if (code == CODE_CAPS) begin
            if (!release_seen) begin
               caps_on = !caps_on;
            end
         end else if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
            shift_on = !release_seen;
         end else if (code == CODE_MOD11) begin
            mod11_on = !release_seen;
         end else if (!release_seen && glyphs[6:0] != 7'd0) begin
            if ((caps_on ^ shift_on) && glyphs[14:8] != 7'd0) begin
               r.ascii_char = glyphs[14:8];
            end else begin
               r.ascii_char = glyphs[6:0];
            end
         end
         if (code != CODE_EXT) begin
            extended_seen = 1'b0;
         end
         release_seen = 1'b0;
      end
      r.shift_held = shift_on;
      r.caps_active = caps_on;
      r.mod11_held = mod11_on;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      key_result_type want;
      if (reset) begin
         release_seen = 1'b0;
         extended_seen = 1'b0;
         caps_on = 1'b0;
         shift_on = 1'b0;
         mod11_on = 1'b0;
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected transaction", int'(rsp_ascii_char), 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_ascii_char != want.ascii_char) begin
                  report_mismatch("ascii_char", int'(rsp_ascii_char),
                                  int'(want.ascii_char));
               end
               if (rsp_shift_held != want.shift_held) begin
                  report_mismatch("shift_held", int'(rsp_shift_held),
                                  int'(want.shift_held));
               end
               if (rsp_caps_active != want.caps_active) begin
                  report_mismatch("caps_active", int'(rsp_caps_active),
                                  int'(want.caps_active));
               end
               if (rsp_mod11_held != want.mod11_held) begin
                  report_mismatch("mod11_held", int'(rsp_mod11_held),
                                  int'(want.mod11_held));
               end
            end
            checked <= checked + 1;
            if (rsp_ascii_char != 7'd0) begin
               char_count <= char_count + 1;
            end
         end
         if (req_valid && req_ready) begin
            expected_q.push_back(translate_byte(req_scan_byte));
         end
      end
      pending <= expected_q.size();
   end

endmodule

FILE: tb/ps2_scancode_to_ascii_tb.sv
// Testbench top for the PS/2 scan code to ASCII translator.
// Drives scan bytes and response back-pressure and gives the verdict;
// depends on the translator RTL, ps2sc_pkg and ps2_scancode_checker.
module ps2_scancode_to_ascii_tb;
   import ps2sc_pkg::*;

   localparam int ITEM_TARGET = 1350;
   localparam int TAIL_START = 1200;
   localparam int HOLD_AT = 400;
   localparam int HOLD_CYCLES = 120;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 400000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic [7:0] req_scan_byte = 8'h00;
   logic       rsp_ready = 1'b0;
   logic       tail_phase = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [6:0] rsp_ascii_char;
   logic       rsp_shift_held;
   logic       rsp_caps_active;
   logic       rsp_mod11_held;

   int cycle_count = 0;
   int bytes_sent = 0;
   int fail_count;
   int pending;
   int checked;
   int char_count;

   logic [7:0] directed_bytes [27] = '{
      8'h00, 8'hFF, 8'h1C, CODE_LSHIFT, 8'h1C, 8'h16, CODE_REL, CODE_LSHIFT,
      CODE_CAPS, 8'h1C, 8'h45, CODE_RSHIFT, 8'h1C, 8'h29, CODE_REL, CODE_RSHIFT,
      CODE_REL, CODE_CAPS, CODE_EXT, 8'h5A, CODE_EXT, CODE_REL, 8'h1C,
      CODE_MOD11, CODE_REL, CODE_MOD11, 8'h76
   };

   logic [7:0] typing_keys [52] = '{
      8'h76, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E,
      8'h46, 8'h45, 8'h4E, 8'h55, 8'h66, 8'h0D, 8'h15, 8'h1D, 8'h24, 8'h2D,
      8'h2C, 8'h35, 8'h3C, 8'h43, 8'h44, 8'h4D, 8'h54, 8'h5B, 8'h5D, 8'h1C,
      8'h1B, 8'h23, 8'h2B, 8'h34, 8'h33, 8'h3B, 8'h42, 8'h4B, 8'h4C, 8'h52,
      8'h5A, 8'h1A, 8'h22, 8'h21, 8'h2A, 8'h32, 8'h31, 8'h3A, 8'h41, 8'h49,
      8'h4A, 8'h29
   };

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ps2_scancode_to_ascii u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_scan_byte   (req_scan_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ascii_char  (rsp_ascii_char),
      .rsp_shift_held  (rsp_shift_held),
      .rsp_caps_active (rsp_caps_active),
      .rsp_mod11_held  (rsp_mod11_held)
   );

   ps2_scancode_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_scan_byte   (req_scan_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ascii_char  (rsp_ascii_char),
      .rsp_shift_held  (rsp_shift_held),
      .rsp_caps_active (rsp_caps_active),
      .rsp_mod11_held  (rsp_mod11_held),
      .fail_count      (fail_count),
      .pending         (pending),
      .checked         (checked),
      .char_count      (char_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ps2_scancode_to_ascii_tb NOT OK");
         $finish;
      end
   end

   // The response side stalls in random bursts and once for a long stretch,
   // which backs the block up into its request side.
   initial begin : response_side
      int len;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (tail_phase) begin
            rsp_ready <= 1'b1;
         end else if (!hold_done && cycle_count >= HOLD_AT) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_done = 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            len = $urandom_range(1, 18);
            repeat (len - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            len = $urandom_range(0, 24);
            repeat (len) @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] code);
      int gap;
      if (!tail_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 18);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_scan_byte <= code;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic tap_key(input logic [7:0] code, input bit extended);
      if (extended) begin
         send_byte(CODE_EXT);
      end
      send_byte(code);
      if (extended) begin
         send_byte(CODE_EXT);
      end
      send_byte(CODE_REL);
      send_byte(code);
   endtask

   function automatic logic [7:0] pick_key();
      return typing_keys[$urandom_range(0, 51)];
   endfunction

   function automatic logic [7:0] pick_shift();
      return ($urandom_range(0, 1) == 0) ? CODE_LSHIFT : CODE_RSHIFT;
   endfunction

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int choice;
      int taps;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_bytes[i]) begin
         send_byte(directed_bytes[i]);
      end
      wait_for_responses();

      while (bytes_sent < ITEM_TARGET) begin
         if (bytes_sent >= TAIL_START) begin
            tail_phase <= 1'b1;
         end
         choice = $urandom_range(0, 99);
         if (choice < 45) begin
            tap_key(pick_key(), $urandom_range(0, 9) == 0);
         end else if (choice < 60) begin
            send_byte(pick_shift());
            taps = $urandom_range(1, 4);
            repeat (taps) tap_key(pick_key(), 1'b0);
            send_byte(CODE_REL);
            send_byte(pick_shift());
         end else if (choice < 68) begin
            tap_key(CODE_CAPS, 1'b0);
         end else if (choice < 74) begin
            send_byte(CODE_MOD11);
            tap_key(pick_key(), 1'b0);
            send_byte(CODE_REL);
            send_byte(CODE_MOD11);
         end else if (choice < 86) begin
            send_byte(($urandom_range(0, 1) == 0) ? CODE_REL : CODE_EXT);
            send_byte(8'($urandom_range(0, 255)));
         end else begin
            send_byte(8'($urandom_range(0, 255)));
         end
      end

      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (pending != 0) begin
         $display("%0d expected responses never arrived", pending);
      end
      $display("Checked %0d responses to %0d scan bytes, %0d of them with a character.",
               checked, bytes_sent, char_count);
      $display("%s%s", "Covered shift and caps lock combinations, release and extended ",
               "prefixes, stray bytes and a long response stall.");
      if (fail_count == 0 && pending == 0) begin
         $display("ps2_scancode_to_ascii_tb OK");
      end else begin
         $display("ps2_scancode_to_ascii_tb NOT OK");
      end
      $finish;
   end

endmodule
